### rtl/core/ust_pkg.sv
// Package for the unordered set table: sizes, operation codes, beat structs
// and the controller/datapath command and status structs.
// No dependencies.
package ust_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int HELD_W   = 7;

    typedef enum logic [1:0] {
        MODE_ADD      = 2'd0,
        MODE_CONTAINS = 2'd1,
        MODE_REMOVE   = 2'd2,
        MODE_CLEAR    = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic              success;
        logic              table_full;
        logic [HELD_W-1:0] entries_held;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic add;
        logic clear;
        logic last_rd;
        logic move;
        logic drop;
        logic respond;
        logic ok;
        logic full;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic hit;
        logic miss;
        logic pos_last;
    } stat_t;

endpackage

### rtl/core/unordered_set_table.sv
// Top level of the unordered set table: controller plus datapath.
// Depends on ust_pkg, ust_ctrl, ust_dp (and ust_ram through ust_dp).
//
//  beat      ports                 handshake
//  request   req (mode, value)     taken when start && !busy
//  result    rsp (success, full,   one-cycle strobe on done, no backpressure
//            entries_held)
//
// Add and clear finish at the accepting edge; done pulses the next cycle and
// busy stays low, so a new request may follow every cycle.
// Contains and remove scan stored entries one per cycle through the single
// RAM read port, with busy high until the scan ends; a remove that hits an
// entry other than the last then reads the last entry and moves it into the
// freed slot. done pulses in the cycle after the last busy cycle.
// Reset clears count and control only; slot contents need no clearing.
module unordered_set_table (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  ust_pkg::req_t req,
    output logic          done,
    output ust_pkg::rsp_t rsp
);
    import ust_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  start_ok;

    assign start_ok = start & ~busy;

    ust_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_ok),
        .mode  (req.mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    ust_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

### rtl/core/ust_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ust_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/ust_ctrl.sv
// Controller for the unordered set table: operation sequencing and busy.
// Depends on ust_pkg.
module ust_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ust_pkg::mode_t mode,
    input  ust_pkg::stat_t stat,
    output ust_pkg::cmd_t  cmd,
    output logic          busy
);
    import ust_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_MOVE
    } state_t;

    state_t state_reg;
    state_t state_next;
    mode_t  mode_reg;
    mode_t  mode_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next = mode;
                    unique case (mode) inside
                        MODE_ADD:
                        begin
                            cmd.respond = 1'b1;
                            if (stat.full)
                            begin
                                cmd.full = 1'b1;
                            end
                            else
                            begin
                                cmd.add = 1'b1;
                                cmd.ok  = 1'b1;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            cmd.clear   = 1'b1;
                            cmd.respond = 1'b1;
                            cmd.ok      = 1'b1;
                        end
                        MODE_CONTAINS, MODE_REMOVE:
                        begin
                            if (stat.empty)
                            begin
                                cmd.respond = 1'b1;
                            end
                            else
                            begin
                                cmd.load   = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            cmd.respond = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    if (mode_reg == MODE_CONTAINS)
                    begin
                        cmd.respond = 1'b1;
                        cmd.ok      = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else if (stat.pos_last)
                    begin
                        cmd.drop    = 1'b1;
                        cmd.respond = 1'b1;
                        cmd.ok      = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_LAST;
                    end
                end
                else if (stat.miss)
                begin
                    cmd.respond = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_LAST:
            begin
                cmd.last_rd = 1'b1;
                state_next  = S_MOVE;
            end
            S_MOVE:
            begin
                cmd.move    = 1'b1;
                cmd.respond = 1'b1;
                cmd.ok      = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_ADD;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

    a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg != S_IDLE))
        else $error("busy out of step with state");

    a_move_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MOVE |-> $past(state_reg) == S_LAST)
        else $error("move without fetch of last entry");

endmodule

### rtl/core/ust_dp.sv
// Datapath for the unordered set table: slot RAM, count, scan pointer,
// match compare and result register. Depends on ust_pkg and ust_ram.
module ust_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  ust_pkg::req_t req,
    input  ust_pkg::cmd_t cmd,
    output ust_pkg::stat_t stat,
    output logic          done,
    output ust_pkg::rsp_t rsp
);
    import ust_pkg::*;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  idx_reg;
    logic              pend_reg;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic [DATA_W-1:0] key_reg;
    logic              done_reg;
    rsp_t              rsp_reg;

    logic [CNT_W-1:0]  cnt_last;
    logic              issue;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
    logic [DATA_W-1:0] rdata;

    assign cnt_last = count_reg - CNT_W'(1);
    assign issue    = (idx_reg < count_reg);

    assign raddr = cmd.last_rd ? cnt_last[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign we    = cmd.add | cmd.move;
    assign waddr = cmd.move ? pos_reg : count_reg[IDX_W-1:0];
    assign wdata = cmd.move ? rdata : DATA_W'(req.value);

    ust_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        stat.empty    = (count_reg == '0);
        stat.full     = (count_reg >= CNT_W'(CAPACITY));
        stat.hit      = pend_reg && (rdata == key_reg);
        stat.miss     = !pend_reg && !issue;
        stat.pos_last = (CNT_W'(pend_idx_reg) == cnt_last);
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.add)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.move || cmd.drop)
        begin
            count_next = cnt_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.respond;
            if (cmd.load)
            begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                pend_reg <= issue;
                if (issue)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= DATA_W'(req.value);
        end
        if (cmd.scan)
        begin
            pend_idx_reg <= idx_reg[IDX_W-1:0];
            if (stat.hit)
            begin
                pos_reg <= pend_idx_reg;
            end
        end
        if (cmd.respond)
        begin
            rsp_reg.success      <= cmd.ok;
            rsp_reg.table_full   <= cmd.full;
            rsp_reg.entries_held <= HELD_W'(count_next);
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(rsp_reg.success && rsp_reg.table_full))
        else $error("success and table_full both set");

    a_move_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.move || cmd.drop) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("remove did not shrink count by one");

endmodule
